// ----- src/mmpa_pkg.sv -----
package mmpa_pkg;

  localparam int unsigned PageW = 20;
  localparam int unsigned CountW = 21;
  localparam int unsigned KindW = 32;

  localparam logic [2:0] OpInsert = 3'd0;
  localparam logic [2:0] OpFinish = 3'd1;
  localparam logic [2:0] OpMark = 3'd2;
  localparam logic [2:0] OpAlloc = 3'd3;
  localparam logic [2:0] OpDump = 3'd4;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StRawExceed = 3'd1;
  localparam logic [2:0] StTableFull = 3'd2;
  localparam logic [2:0] StLimitBelow = 3'd3;
  localparam logic [2:0] StFixedCollide = 3'd4;
  localparam logic [2:0] StOutOfMemory = 3'd5;
  localparam logic [2:0] StHalted = 3'd6;

  localparam logic CfgAllocBase = 1'b0;
  localparam logic CfgAvailType = 1'b1;

  localparam logic [31:0] PageMask = 32'hFFFF_F000;
  localparam logic [31:0] BaseReset = 32'h0100_0000;
  localparam logic [31:0] AvailReset = 32'd1;
  localparam logic [20:0] TopPage = 21'h10_0000;

  // One table entry: start page, page count (up to the whole space), kind.
  typedef struct packed {
    logic [PageW-1:0] start;
    logic [CountW-1:0] count;
    logic [KindW-1:0] kind;
  } seg_t;

endpackage

// ----- src/memory_map_merge_page_allocator.sv -----
// Boot memory-map merger with a bump page allocator. Insert (opcode 0) clips a
// raw region to 4 GiB, rounds it to 4 KiB pages and merges it into a sorted
// table of disjoint segments held in one synchronous memory; reserved kinds
// override what they overlap, the available kind only fills gaps. Finish (1)
// sets the allocation limit from the free segment holding allocation_base,
// mark allocated (2) lowers it, allocate page (3) bumps a pointer, dump (4)
// emits one beat per segment. Every failure sets a sticky halt, after which
// each item returns status 6. Mark, allocate, unknown codes, an insert that
// is dropped or overflows the raw count, finish or dump on an empty table and
// any item on a halted block answer in the cycle after the item is taken;
// finish reads and checks each entry in turn and answers with its last step;
// dump reads each entry and sends it as one beat, waiting while the receiver
// stalls. An insert reads and checks the table entry by entry, and each split
// or slot opening shifts the tail upward one entry at a time through the
// single memory port (read, then write), followed by one or two split writes.
// Results go out through one output register, the next item is taken once
// the previous result beats are all sent.
module memory_map_merge_page_allocator
  import mmpa_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [63:0] region_base_i,
  input  logic [63:0] region_length_i,
  input  logic [31:0] region_type_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] result_address_o,
  output logic [32:0] entry_length_o,
  output logic [31:0] entry_type_o,
  output logic        entry_is_free_o,
  output logic        entry_valid_o,
  output logic        overlap_warning_o,
  output logic        last_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] Full = CntW'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EVAL, S_SHRD, S_SHWR, S_SPLIT, S_APPEND,
    S_FIN, S_DUMP, S_OUT
  } state_e;

  // Split actions that follow the shift that opened a slot.
  typedef enum logic [1:0] {
    A_GAP, A_HEAD, A_MID
  } act_e;

  seg_t mem_q [TABLE_ENTRIES];
  seg_t rd_q;
  logic [IdxW-1:0] ra;
  logic we;
  logic [IdxW-1:0] wa;
  seg_t wd;

  state_e state_q;
  act_e act_q;
  logic [31:0] base_q, avail_q, next_q, limit_q;
  logic [CntW-1:0] seg_cnt_q, raw_cnt_q, fix_cnt_q;
  logic halted_q;
  logic [CntW-1:0] j_q, k_q;
  logic [20:0] b_q, e_q;
  logic [31:0] t_q;
  logic warn_q;
  logic [2:0] op_q;
  seg_t cur_q;
  logic mid_hi_q;  // second half of a split write

  logic ov_q, ol_q;
  logic [2:0] st_q;
  logic [31:0] addr_q, typ_q;
  logic [32:0] len_q;
  logic free_q, ev_q, warno_q;

  assign in_ready_o = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign result_address_o = addr_q;
  assign entry_length_o = len_q;
  assign entry_type_o = typ_q;
  assign entry_is_free_o = free_q;
  assign entry_valid_o = ev_q;
  assign overlap_warning_o = warno_q;
  assign last_o = ol_q;

  // Single-port table memory, read data registered.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  // Region clipping for insert.
  logic [32:0] clip_sum;
  logic [32:0] clen;
  logic [33:0] rlen;
  logic [20:0] bp, ep;
  always_comb begin
    clip_sum = {1'b0, region_base_i[31:0]} + {1'b0, region_length_i[31:0]};
    if (region_length_i[63:32] != '0 || clip_sum[32]) begin
      clen = 33'h1_0000_0000 - {1'b0, region_base_i[31:0]};
    end else begin
      clen = region_length_i[32:0];
    end
    rlen = {1'b0, clen} + 34'hFFF;
    bp = {1'b0, region_base_i[31:12]};
    ep = bp + rlen[32:12];
    if (ep > TopPage) begin
      ep = TopPage;
    end
  end

  logic [32:0] mlen;
  logic [31:0] mb;
  assign mb = region_base_i[31:0] & PageMask;
  assign mlen = ({1'b0, region_length_i[31:0]} + 33'hFFF) & {21'h1F_FFFF, 12'h0};

  logic [20:0] s_end;
  assign s_end = {1'b0, cur_q.start} + cur_q.count;
  logic [20:0] e_min_s;
  assign e_min_s = (e_q < {1'b0, cur_q.start}) ? e_q : {1'b0, cur_q.start};

  logic [20:0] rd_end;
  assign rd_end = {1'b0, rd_q.start} + rd_q.count;
  logic ev_kind_we;
  assign ev_kind_we = (state_q == S_EVAL) && (b_q < rd_end) && (t_q != avail_q)
                      && (b_q == {1'b0, rd_q.start}) && (e_q >= rd_end);

  always_comb begin
    ra = j_q[IdxW-1:0];
    if (state_q == S_SHRD) begin
      ra = IdxW'(k_q - CntW'(1));
    end
  end

  // Memory writes.
  always_comb begin
    we = 1'b0;
    wa = j_q[IdxW-1:0];
    wd = cur_q;
    case (state_q)
      S_SHWR: begin
        we = 1'b1;
        wa = k_q[IdxW-1:0];
        wd = rd_q;
      end
      S_SPLIT: begin
        we = 1'b1;
        case (act_q)
          A_GAP: begin
            wd.start = b_q[19:0];
            wd.count = e_min_s - b_q;
            wd.kind = t_q;
          end
          A_HEAD: begin
            if (!mid_hi_q) begin
              wd.count = b_q - {1'b0, cur_q.start};
            end else begin
              wa = IdxW'(j_q + CntW'(1));
              wd.start = b_q[19:0];
              wd.count = s_end - b_q;
            end
          end
          A_MID: begin
            if (!mid_hi_q) begin
              wd.start = b_q[19:0];
              wd.count = e_q - b_q;
              wd.kind = t_q;
            end else begin
              wa = IdxW'(j_q + CntW'(1));
              wd.start = e_q[19:0];
              wd.count = s_end - e_q;
            end
          end
          default: ;
        endcase
      end
      S_EVAL: begin
        // Whole covered segment takes the new kind.
        if (ev_kind_we) begin
          we = 1'b1;
          wd = rd_q;
          wd.kind = t_q;
        end
      end
      S_APPEND: begin
        // Write only when a tail remains and the table has room.
        we = (b_q < e_q) && (seg_cnt_q < Full);
        wa = seg_cnt_q[IdxW-1:0];
        wd.start = b_q[19:0];
        wd.count = e_q - b_q;
        wd.kind = t_q;
      end
      default: ;
    endcase
  end

  // Finish scan address math.
  logic [32:0] fs, fe;
  assign fs = {1'b0, rd_q.start, 12'h0};
  assign fe = fs + {rd_q.count, 12'h0};
  logic fin_hit;
  logic [31:0] fin_lim;
  assign fin_hit = (rd_q.kind == avail_q) && (fs <= {1'b0, base_q}) && (fe > {1'b0, base_q});
  assign fin_lim = fe[32] ? PageMask : fe[31:0];

  task automatic emit(input logic [2:0] st, input logic [31:0] addr, input logic warn);
    st_q <= st;
    addr_q <= addr;
    len_q <= '0;
    typ_q <= '0;
    free_q <= 1'b0;
    ev_q <= 1'b0;
    warno_q <= warn;
    ol_q <= 1'b1;
    ov_q <= 1'b1;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q <= A_GAP;
      base_q <= BaseReset;
      avail_q <= AvailReset;
      next_q <= BaseReset;
      limit_q <= BaseReset;
      seg_cnt_q <= '0;
      raw_cnt_q <= '0;
      fix_cnt_q <= '0;
      halted_q <= 1'b0;
      ov_q <= 1'b0;
      ol_q <= 1'b0;
      j_q <= '0;
      k_q <= '0;
      mid_hi_q <= 1'b0;
      warn_q <= 1'b0;
      b_q <= '0;
      e_q <= '0;
      t_q <= '0;
      op_q <= OpInsert;
      cur_q <= '0;
      st_q <= StOk;
      addr_q <= '0;
      len_q <= '0;
      typ_q <= '0;
      free_q <= 1'b0;
      ev_q <= 1'b0;
      warno_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgAllocBase) begin
          base_q <= cfg_data_i & PageMask;
          next_q <= cfg_data_i & PageMask;
          limit_q <= cfg_data_i & PageMask;
        end else begin
          avail_q <= cfg_data_i;
        end
      end
      if (ov_q && out_ready_i && state_q != S_DUMP) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            op_q <= opcode_i;
            j_q <= '0;
            warn_q <= 1'b0;
            if (halted_q) begin
              emit(StHalted, '0, 1'b0);
            end else begin
              case (opcode_i)
                OpInsert: begin
                  if (raw_cnt_q >= Full) begin
                    emit(StRawExceed, '0, 1'b0);
                    halted_q <= 1'b1;
                  end else begin
                    raw_cnt_q <= raw_cnt_q + CntW'(1);
                    if (region_base_i[63:32] != '0 || bp >= ep) begin
                      emit(StOk, '0, 1'b0);
                    end else begin
                      b_q <= bp;
                      e_q <= ep;
                      t_q <= region_type_i;
                      state_q <= (seg_cnt_q == '0) ? S_APPEND : S_RD;
                    end
                  end
                end
                OpFinish: begin
                  if (seg_cnt_q == '0) begin
                    emit(StOk, limit_q, 1'b0);
                  end else begin
                    state_q <= S_FIN;
                    mid_hi_q <= 1'b0;
                  end
                end
                OpMark: begin
                  if (fix_cnt_q >= Full) begin
                    emit(StTableFull, limit_q, 1'b0);
                    halted_q <= 1'b1;
                  end else begin
                    fix_cnt_q <= fix_cnt_q + CntW'(1);
                    if (mb < limit_q && mb >= base_q) begin
                      limit_q <= mb;
                      if (mb < next_q) begin
                        emit(StLimitBelow, mb, 1'b0);
                        halted_q <= 1'b1;
                      end else begin
                        emit(StOk, mb, 1'b0);
                      end
                    end else if (mb < limit_q &&
                                 ({1'b0, mb} + mlen) > {1'b0, limit_q}) begin
                      emit(StFixedCollide, limit_q, 1'b0);
                      halted_q <= 1'b1;
                    end else begin
                      emit(StOk, limit_q, 1'b0);
                    end
                  end
                end
                OpAlloc: begin
                  if (({1'b0, next_q} + 33'h1000) > {1'b0, limit_q}) begin
                    emit(StOutOfMemory, '0, 1'b0);
                    halted_q <= 1'b1;
                  end else begin
                    emit(StOk, next_q, 1'b0);
                    next_q <= next_q + 32'h1000;
                  end
                end
                OpDump: begin
                  if (seg_cnt_q == '0) begin
                    emit(StOk, '0, 1'b0);
                  end else begin
                    state_q <= S_FIN;
                    mid_hi_q <= 1'b0;
                  end
                end
                default: begin
                  emit(StOk, '0, 1'b0);
                end
              endcase
            end
          end
        end
        S_RD: begin
          // Memory read of entry j in flight.
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          cur_q <= rd_q;
          if (b_q >= rd_end) begin
            j_q <= j_q + CntW'(1);
            state_q <= (j_q + CntW'(1) < seg_cnt_q) ? S_RD : S_APPEND;
          end else if (b_q < {1'b0, rd_q.start}) begin
            if (seg_cnt_q >= Full) begin
              emit(StTableFull, '0, warn_q);
              halted_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              act_q <= A_GAP;
              k_q <= seg_cnt_q;
              state_q <= S_SHRD;
            end
          end else begin
            warn_q <= 1'b1;
            if (t_q == avail_q) begin
              b_q <= (e_q < rd_end) ? e_q : rd_end;
              j_q <= j_q + CntW'(1);
              state_q <= (j_q + CntW'(1) < seg_cnt_q && e_q > rd_end) ? S_RD : S_APPEND;
            end else if (b_q > {1'b0, rd_q.start} || e_q < rd_end) begin
              if (seg_cnt_q >= Full) begin
                emit(StTableFull, '0, 1'b1);
                halted_q <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                act_q <= (b_q > {1'b0, rd_q.start}) ? A_HEAD : A_MID;
                k_q <= seg_cnt_q;
                state_q <= S_SHRD;
              end
            end else begin
              // Kind rewritten this cycle; advance past the segment.
              b_q <= rd_end;
              j_q <= j_q + CntW'(1);
              state_q <= (j_q + CntW'(1) < seg_cnt_q && e_q > rd_end) ? S_RD : S_APPEND;
            end
          end
        end
        S_SHRD: begin
          if (k_q > j_q) begin
            state_q <= S_SHWR;
          end else begin
            seg_cnt_q <= seg_cnt_q + CntW'(1);
            mid_hi_q <= 1'b0;
            state_q <= S_SPLIT;
          end
        end
        S_SHWR: begin
          k_q <= k_q - CntW'(1);
          state_q <= S_SHRD;
        end
        S_SPLIT: begin
          case (act_q)
            A_GAP: begin
              if (e_q <= {1'b0, cur_q.start}) begin
                b_q <= e_q;
                state_q <= S_APPEND;
              end else begin
                b_q <= {1'b0, cur_q.start};
                j_q <= j_q + CntW'(1);
                state_q <= S_RD;
              end
            end
            A_HEAD: begin
              if (!mid_hi_q) begin
                mid_hi_q <= 1'b1;
              end else begin
                // Continue on the upper half, now at j+1.
                j_q <= j_q + CntW'(1);
                state_q <= S_RD;
              end
            end
            default: begin
              if (!mid_hi_q) begin
                mid_hi_q <= 1'b1;
              end else begin
                b_q <= e_q;
                state_q <= S_APPEND;
              end
            end
          endcase
        end
        S_APPEND: begin
          // Write happens here only when gap remains; count follows.
          if (b_q < e_q) begin
            if (seg_cnt_q >= Full) begin
              emit(StTableFull, '0, warn_q);
              halted_q <= 1'b1;
            end else begin
              seg_cnt_q <= seg_cnt_q + CntW'(1);
              emit(StOk, '0, warn_q);
            end
          end else begin
            emit(StOk, '0, warn_q);
          end
          state_q <= S_IDLE;
        end
        S_FIN: begin
          // Read of entry j in flight.
          state_q <= (op_q == OpDump) ? S_DUMP : S_OUT;
        end
        S_OUT: begin
          if (fin_hit) begin
            limit_q <= fin_lim;
          end
          if (j_q + CntW'(1) < seg_cnt_q) begin
            j_q <= j_q + CntW'(1);
            state_q <= S_FIN;
          end else begin
            // Last entry checked: send the limit, including this entry's hit.
            emit(StOk, fin_hit ? fin_lim : limit_q, 1'b0);
            state_q <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (!ov_q || out_ready_i) begin
            st_q <= StOk;
            addr_q <= fs[31:0];
            len_q <= {rd_q.count, 12'h0};
            typ_q <= rd_q.kind;
            free_q <= rd_q.kind == avail_q;
            ev_q <= 1'b1;
            warno_q <= 1'b0;
            ol_q <= j_q + CntW'(1) == seg_cnt_q;
            ov_q <= 1'b1;
            if (j_q + CntW'(1) < seg_cnt_q) begin
              j_q <= j_q + CntW'(1);
              state_q <= S_FIN;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_cnt_q <= Full) else $error("segment count beyond table size");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(halted_q) |-> halted_q) else $error("halt cleared");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("item taken while result pending");

endmodule
